/* sv/h2r_pkg.sv */
// Shared constants, types and helpers of the HSV to RGB pixel converter.
package h2r_pkg;

    localparam logic [7:0]  FULL_SCALE    = 8'd255;
    localparam logic [15:0] FULL_SCALE_SQ = 16'd65025;

    typedef logic [2:0] t_sector;

    localparam t_sector SEC_0 = 3'd0;
    localparam t_sector SEC_1 = 3'd1;
    localparam t_sector SEC_2 = 3'd2;
    localparam t_sector SEC_3 = 3'd3;
    localparam t_sector SEC_4 = 3'd4;
    localparam t_sector SEC_5 = 3'd5;

    // hue split into sector and position inside it, plus the pixel's other channels
    typedef struct packed {
        t_sector    sector;
        logic [7:0] fn;
        logic [7:0] sat;
        logic [7:0] bri;
        logic       zero;
    } t_stage_a;

    // floor(x / 255), exact for x up to 65025
    function automatic logic [7:0] div255_16(input logic [15:0] x);
        logic [16:0] acc;
        acc = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return acc[15:8];
    endfunction

endpackage

/* sv/h2r_hsv_if.sv */
// Input channel: one HSV pixel word per handshake.
interface h2r_hsv_if;
    logic       valid;
    logic       ready;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

/* sv/h2r_rgb_if.sv */
// Output channel: one RGB pixel word per handshake.
interface h2r_rgb_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

/* sv/h2r_sector.sv */
// First pipeline stage: hue sector search and in-sector fraction.
module h2r_sector (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [7:0]        i_hue,
    input  logic [7:0]        i_sat,
    input  logic [7:0]        i_bri,
    output h2r_pkg::t_stage_a o_stage
);
    import h2r_pkg::*;

    localparam logic [10:0] STEP = 11'(FULL_SCALE);
    localparam logic [10:0] B1   = 11'(1 * FULL_SCALE);
    localparam logic [10:0] B2   = 11'(2 * FULL_SCALE);
    localparam logic [10:0] B3   = 11'(3 * FULL_SCALE);
    localparam logic [10:0] B4   = 11'(4 * FULL_SCALE);
    localparam logic [10:0] B5   = 11'(5 * FULL_SCALE);
    localparam logic [10:0] B6   = 11'(6 * FULL_SCALE);

    logic [10:0] h6;
    logic [10:0] base;
    logic [10:0] frac;
    t_sector     sec;
    t_stage_a    n_stage;
    t_stage_a    r_stage;

    assign h6 = {1'b0, i_hue, 2'b00} + {2'b00, i_hue, 1'b0};

    always_comb begin
        // a full turn wraps back to sector 0
        if (h6 >= B6) begin
            sec  = SEC_0;
            base = B6;
        end else if (h6 >= B5) begin
            sec  = SEC_5;
            base = B5;
        end else if (h6 >= B4) begin
            sec  = SEC_4;
            base = B4;
        end else if (h6 >= B3) begin
            sec  = SEC_3;
            base = B3;
        end else if (h6 >= B2) begin
            sec  = SEC_2;
            base = B2;
        end else if (h6 >= B1) begin
            sec  = SEC_1;
            base = B1;
        end else begin
            sec  = SEC_0;
            base = STEP - STEP;
        end
        frac = h6 - base;

        n_stage.sector = sec;
        n_stage.fn     = frac[7:0];
        n_stage.sat    = i_sat;
        n_stage.bri    = i_bri;
        n_stage.zero   = (i_sat == 8'd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

/* sv/h2r_div255w.sv */
// Two-stage floor(x / 255) for 24-bit x: reciprocal estimate, then one correction.
module h2r_div255w (
    input  logic        i_clk,
    input  logic [1:0]  i_en,
    input  logic [23:0] i_num,
    output logic [15:0] o_quo
);
    import h2r_pkg::*;

    logic [32:0] prod;
    logic [23:0] r_num;
    logic [15:0] r_est;
    logic [23:0] back;
    logic [23:0] rem;
    logic [15:0] r_quo;

    // x*257/2^16 sits just under x/255, so the estimate is short by at most one
    assign prod = {9'd0, i_num} * 33'd257;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_num <= i_num;
            r_est <= prod[31:16];
        end
    end

    assign back = {r_est, 8'd0} - {8'd0, r_est};
    assign rem  = r_num - back;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_quo <= r_est + 16'(rem >= 24'(FULL_SCALE));
        end
    end

    assign o_quo = r_quo;

endmodule

/* sv/hsv_to_rgb_pixel_core.sv */
// HSV to RGB pixel converter, 8 bits per channel, six register stages.
// Each accepted word passes through the registered stages A to F in order before it reaches the output.
// Throughput: one pixel per clock; each stage stalls only when it and all later stages are full.
// The multiplier stages B and C take a new set of products every clock in which they are not stalled.
// Reset clears the stage valid bits only; the datapath registers are not reset.
module hsv_to_rgb_pixel_core (
    input  logic   i_clk,
    input  logic   i_rst_n,
    h2r_hsv_if.sink   i_pix,
    h2r_rgb_if.source o_pix
);
    import h2r_pkg::*;

    localparam int STAGES = 6;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;
    logic [STAGES-1:0] rdy;

    always_comb begin
        rdy[STAGES-1] = !r_vld[STAGES-1] || o_pix.ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
        n_vld[0] = rdy[0] ? i_pix.valid : r_vld[0];
        for (int k = 1; k < STAGES; k++) begin
            n_vld[k] = rdy[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign i_pix.ready = rdy[0];

    // stage A: sector and fraction
    t_stage_a a_stage;

    h2r_sector u_sector (
        .i_clk   (i_clk),
        .i_en    (rdy[0]),
        .i_hue   (i_pix.hue),
        .i_sat   (i_pix.saturation),
        .i_bri   (i_pix.brightness),
        .o_stage (a_stage)
    );

    // stage B: s*f, s*(1-f), v*(1-s)
    logic [7:0]  fc;
    logic [7:0]  dsat;
    logic [15:0] r_b_sfn;
    logic [15:0] r_b_sfc;
    logic [15:0] r_b_pv;
    logic [7:0]  r_b_bri;
    t_sector     r_b_sector;
    logic        r_b_zero;

    assign fc   = FULL_SCALE - a_stage.fn;
    assign dsat = FULL_SCALE - a_stage.sat;

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_b_sfn    <= {8'd0, a_stage.sat} * {8'd0, a_stage.fn};
            r_b_sfc    <= {8'd0, a_stage.sat} * {8'd0, fc};
            r_b_pv     <= {8'd0, a_stage.bri} * {8'd0, dsat};
            r_b_bri    <= a_stage.bri;
            r_b_sector <= a_stage.sector;
            r_b_zero   <= a_stage.zero;
        end
    end

    // stage C: numerators over 65025, and p
    logic [15:0] tq;
    logic [15:0] tt;
    logic [23:0] r_c_xq;
    logic [23:0] r_c_xt;
    logic [7:0]  r_c_p;
    logic [7:0]  r_c_bri;
    t_sector     r_c_sector;
    logic        r_c_zero;

    assign tq = FULL_SCALE_SQ - r_b_sfn;
    assign tt = FULL_SCALE_SQ - r_b_sfc;

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r_c_xq     <= {16'd0, r_b_bri} * {8'd0, tq};
            r_c_xt     <= {16'd0, r_b_bri} * {8'd0, tt};
            r_c_p      <= div255_16(r_b_pv);
            r_c_bri    <= r_b_bri;
            r_c_sector <= r_b_sector;
            r_c_zero   <= r_b_zero;
        end
    end

    // stages D and E: first division by 255
    logic [15:0] yq;
    logic [15:0] yt;

    h2r_div255w u_div_q (
        .i_clk (i_clk),
        .i_en  (rdy[4:3]),
        .i_num (r_c_xq),
        .o_quo (yq)
    );

    h2r_div255w u_div_t (
        .i_clk (i_clk),
        .i_en  (rdy[4:3]),
        .i_num (r_c_xt),
        .o_quo (yt)
    );

    logic [7:0] r_d_p;
    logic [7:0] r_d_bri;
    t_sector    r_d_sector;
    logic       r_d_zero;
    logic [7:0] r_e_p;
    logic [7:0] r_e_bri;
    t_sector    r_e_sector;
    logic       r_e_zero;

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r_d_p      <= r_c_p;
            r_d_bri    <= r_c_bri;
            r_d_sector <= r_c_sector;
            r_d_zero   <= r_c_zero;
        end
        if (rdy[4]) begin
            r_e_p      <= r_d_p;
            r_e_bri    <= r_d_bri;
            r_e_sector <= r_d_sector;
            r_e_zero   <= r_d_zero;
        end
    end

    // stage F: second division by 255 and sector placement
    logic [7:0] q8;
    logic [7:0] t8;
    logic [7:0] n_red;
    logic [7:0] n_green;
    logic [7:0] n_blue;
    logic [7:0] r_red;
    logic [7:0] r_green;
    logic [7:0] r_blue;

    assign q8 = div255_16(yq);
    assign t8 = div255_16(yt);

    always_comb begin
        if (r_e_zero) begin
            n_red   = r_e_bri;
            n_green = r_e_bri;
            n_blue  = r_e_bri;
        end else begin
            case (r_e_sector)
                SEC_1: begin
                    n_red = q8;      n_green = r_e_bri; n_blue = r_e_p;
                end
                SEC_2: begin
                    n_red = r_e_p;   n_green = r_e_bri; n_blue = t8;
                end
                SEC_3: begin
                    n_red = r_e_p;   n_green = q8;      n_blue = r_e_bri;
                end
                SEC_4: begin
                    n_red = t8;      n_green = r_e_p;   n_blue = r_e_bri;
                end
                SEC_5: begin
                    n_red = r_e_bri; n_green = r_e_p;   n_blue = q8;
                end
                default: begin
                    n_red = r_e_bri; n_green = t8;      n_blue = r_e_p;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_pix.valid = r_vld[5];
    assign o_pix.red   = r_red;
    assign o_pix.green = r_green;
    assign o_pix.blue  = r_blue;

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> r_vld[0])
        else $error("accepted word did not enter the first stage");

    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[2] && !rdy[3]) |=> r_vld[2])
        else $error("stalled word lost from the multiply stage");

    a_drain_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[4] && rdy[4]) |=> r_vld[5])
        else $error("word leaving the divider did not reach the output register");

endmodule
